// ===== hw/rtl/bdpt_pkg.sv =====
// Shared types and constants of the button debounce and push timer block.
package bdpt_pkg;

    // Widths of the transaction fields.
    localparam int OpW        = 3;
    localparam int BtnW       = 2;
    localparam int RawW       = 3;
    localparam int FlagW      = 3;
    localparam int FilterW    = 8;
    localparam int HoldW      = 16;

    // Default and legal range of the button count.
    localparam int NumButtons = 3;
    localparam int MaxButtons = 32;

    // Reset value of the filter register.
    localparam logic [FilterW-1:0] FilterReset = 8'd4;

    // Event latch encoding: bit 0 pushed, bit 1 pulled.
    localparam logic [1:0] LatchPushed = 2'b01;
    localparam logic [1:0] LatchPulled = 2'b10;

    // Hold time arithmetic in milliseconds.
    localparam logic [HoldW-1:0] HoldStep    = 16'd10;
    localparam logic [HoldW-1:0] HoldSatEdge = 16'd65520;
    localparam logic [HoldW-1:0] HoldMax     = 16'hFFFF;

    typedef enum logic [OpW-1:0] {
        OP_TICK       = 3'd0,
        OP_CLR_PUSHED = 3'd1,
        OP_CLR_PULLED = 3'd2,
        OP_CLR_TIME   = 3'd3,
        OP_QUERY      = 3'd4
    } op_t;

    // Command that the top level hands to every lane.
    typedef struct packed {
        logic                accept;
        logic [OpW-1:0]      op;
        logic                sel;
        logic                level;
        logic [FilterW-1:0]  filter;
    } lane_cmd_t;

    // State of one lane after the current transaction.
    typedef struct packed {
        logic               level;
        logic               pushed;
        logic               pulled;
        logic [HoldW-1:0]   hold;
    } lane_state_t;

    // Output-stage control between the top level and the merge stage.
    typedef struct packed {
        logic accept;
        logic take;
    } merge_ctrl_t;

endpackage

// ===== hw/rtl/bdpt_if.sv =====
// Handshake interfaces for the request, response and configuration channels.
interface bdpt_req_if
    import bdpt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OpW-1:0]      op;
    logic [BtnW-1:0]     button;
    logic [RawW-1:0]     raw_levels;

    modport source (output valid, op, button, raw_levels, input ready);
    modport sink   (input valid, op, button, raw_levels, output ready);
endinterface

interface bdpt_rsp_if
    import bdpt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [FlagW-1:0]    filtered_levels;
    logic [FlagW-1:0]    pushed_flags;
    logic [FlagW-1:0]    pulled_flags;
    logic [HoldW-1:0]    push_time_ms;

    modport source (output valid, filtered_levels, pushed_flags, pulled_flags,
                    push_time_ms, input ready);
    modport sink   (input valid, filtered_levels, pushed_flags, pulled_flags,
                    push_time_ms, output ready);
endinterface

interface bdpt_cfg_if
    import bdpt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [FilterW-1:0]  filter_ticks;

    modport source (output valid, filter_ticks, input ready);
    modport sink   (input valid, filter_ticks, output ready);
endinterface

// ===== hw/rtl/bdpt_lane.sv =====
// Debounce filter, event latches and hold timer for a single button.
module bdpt_lane
    import bdpt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  lane_cmd_t    cmd,
    output lane_state_t  state_next
);

    logic               stable_reg, stable_next;
    logic [FilterW-1:0] count_reg,  count_next;
    logic [1:0]         latch_reg,  latch_next;
    logic [HoldW-1:0]   hold_reg,   hold_next;
    logic               mismatch;
    logic [HoldW-1:0]   hold_first;

    assign mismatch   = stable_reg != cmd.level;
    assign hold_first = HoldW'(cmd.filter) * HoldStep;

    always_comb
    begin
        stable_next = stable_reg;
        count_next  = count_reg;
        latch_next  = latch_reg;
        hold_next   = hold_reg;
        if (cmd.accept)
        begin
            unique case (op_t'(cmd.op))
                OP_TICK:
                begin
                    if (mismatch)
                    begin
                        if (count_reg < cmd.filter)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            stable_next = cmd.level;
                            latch_next  = latch_reg | (cmd.level ? LatchPushed : LatchPulled);
                        end
                    end
                    else
                    begin
                        count_next = '0;
                        if (latch_reg == LatchPushed && hold_reg != HoldMax)
                        begin
                            if (hold_reg == '0)
                            begin
                                hold_next = hold_first;
                            end
                            else if (hold_reg > HoldSatEdge)
                            begin
                                hold_next = HoldMax;
                            end
                            else
                            begin
                                hold_next = hold_reg + HoldStep;
                            end
                        end
                    end
                end
                OP_CLR_PUSHED:
                begin
                    if (cmd.sel)
                    begin
                        latch_next = latch_reg & ~LatchPushed;
                    end
                end
                OP_CLR_PULLED:
                begin
                    if (cmd.sel)
                    begin
                        latch_next = latch_reg & ~LatchPulled;
                    end
                end
                OP_CLR_TIME:
                begin
                    if (cmd.sel)
                    begin
                        hold_next = '0;
                    end
                end
                default:
                begin
                    // Query and unused codes leave the state alone.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= 1'b0;
            count_reg  <= '0;
            latch_reg  <= '0;
            hold_reg   <= '0;
        end
        else
        begin
            stable_reg <= stable_next;
            count_reg  <= count_next;
            latch_reg  <= latch_next;
            hold_reg   <= hold_next;
        end
    end

    assign state_next.level  = stable_next;
    assign state_next.pushed = latch_next[0];
    assign state_next.pulled = latch_next[1];
    assign state_next.hold   = hold_next;

    // A tick that agrees with the stable level always restarts the filter.
    a_match_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && cmd.op == OP_TICK && !mismatch) |=> (count_reg == '0))
        else $error("mismatch counter not cleared by a matching tick");

    // An accepted level change always leaves the matching event latched.
    a_change_latches: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && cmd.op == OP_TICK && mismatch && !(count_reg < cmd.filter))
        |=> (stable_reg ? latch_reg[0] : latch_reg[1]))
        else $error("level change without its event latch");

    // The hold time moves only with a transaction.
    a_hold_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.accept |=> $stable(hold_reg))
        else $error("hold time changed without a transaction");

endmodule

// ===== hw/rtl/bdpt_merge.sv =====
// Merge stage: gathers the lane states into one registered response.
module bdpt_merge
    import bdpt_pkg::*;
#(
    parameter int BUTTONS = NumButtons
)(
    input  logic          clk,
    input  logic          rst_n,
    input  merge_ctrl_t   ctrl,
    input  logic [BtnW-1:0] button,
    input  lane_state_t   lanes [BUTTONS],
    bdpt_rsp_if.source    rsp
);

    logic               valid_reg, valid_next;
    logic [FlagW-1:0]   level_reg, pushed_reg, pulled_reg;
    logic [FlagW-1:0]   level_bits, pushed_bits, pulled_bits;
    logic [HoldW-1:0]   hold_reg, hold_sel;

    // Only the first three buttons fit the flag fields.
    for (genvar i = 0; i < FlagW; i++)
    begin : g_flag
        if (i < BUTTONS)
        begin : g_used
            assign level_bits[i]  = lanes[i].level;
            assign pushed_bits[i] = lanes[i].pushed;
            assign pulled_bits[i] = lanes[i].pulled;
        end
        else
        begin : g_unused
            assign level_bits[i]  = 1'b0;
            assign pushed_bits[i] = 1'b0;
            assign pulled_bits[i] = 1'b0;
        end
    end

    // A button index with no lane selects nothing and reports zero.
    always_comb
    begin
        hold_sel = '0;
        for (int i = 0; i < BUTTONS; i++)
        begin
            if (int'(button) == i)
            begin
                hold_sel = hold_sel | lanes[i].hold;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.accept)
        begin
            valid_next = 1'b1;
        end
        else if (ctrl.take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            level_reg  <= level_bits;
            pushed_reg <= pushed_bits;
            pulled_reg <= pulled_bits;
            hold_reg   <= hold_sel;
        end
    end

    assign rsp.valid           = valid_reg;
    assign rsp.filtered_levels = level_reg;
    assign rsp.pushed_flags    = pushed_reg;
    assign rsp.pulled_flags    = pulled_reg;
    assign rsp.push_time_ms    = hold_reg;

endmodule

// ===== hw/rtl/button_debounce_push_timer_core.sv =====
// Top level of the button debounce and push timer block.
//
//  Channel | Direction | Payload                                        | Per transaction
//  --------+-----------+------------------------------------------------+----------------
//  req     | in        | op, button, raw_levels                         | one operation
//  rsp     | out       | filtered_levels, pushed_flags, pulled_flags,   | one response
//          |           | push_time_ms                                   |
//  cfg     | in        | filter_ticks                                   | one register write
//
// Every request is finished in the cycle it is accepted: all button lanes
// update their state in parallel and the merge stage registers the response,
// which appears in the next cycle. A new request is accepted every cycle as
// long as the response register is empty or is being drained in that same
// cycle, so the sustained rate is one transaction per cycle; the single
// response register is what sets that limit under back pressure.
// The configuration channel is always ready and takes effect on the next
// request. Reset is asynchronous and active low: all buttons read released,
// counters, latches and hold times are zero, and the filter is four ticks.
module button_debounce_push_timer_core
    import bdpt_pkg::*;
#(
    parameter int BUTTONS = NumButtons
)(
    input  logic        clk,
    input  logic        rst_n,
    bdpt_req_if.sink    req,
    bdpt_rsp_if.source  rsp,
    bdpt_cfg_if.sink    cfg
);

    logic [FilterW-1:0] filter_reg, filter_next;
    logic               accept;
    lane_state_t        lane_state [BUTTONS];
    merge_ctrl_t        merge_ctrl;

    // The configuration register can always take a write.
    assign cfg.ready   = 1'b1;
    assign filter_next = (cfg.valid && cfg.ready) ? cfg.filter_ticks : filter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg <= FilterReset;
        end
        else
        begin
            filter_reg <= filter_next;
        end
    end

    // A request is taken whenever the response register is free or emptying.
    assign req.ready         = !rsp.valid || rsp.ready;
    assign accept            = req.valid && req.ready;
    assign merge_ctrl.accept = accept;
    assign merge_ctrl.take   = rsp.valid && rsp.ready;

    // One lane per button. Buttons beyond the raw field see a released level.
    for (genvar i = 0; i < BUTTONS; i++)
    begin : g_lane
        lane_cmd_t cmd;

        assign cmd.accept = accept;
        assign cmd.op     = req.op;
        assign cmd.sel    = (int'(req.button) == i);
        assign cmd.filter = filter_reg;
        if (i < RawW)
        begin : g_raw
            assign cmd.level = req.raw_levels[i];
        end
        else
        begin : g_none
            assign cmd.level = 1'b0;
        end

        bdpt_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .state_next (lane_state[i])
        );
    end

    bdpt_merge #(
        .BUTTONS (BUTTONS)
    ) u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (merge_ctrl),
        .button (req.button),
        .lanes  (lane_state),
        .rsp    (rsp)
    );

endmodule
